@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Field widths, default sizes and request and status codes of the heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 16;

   localparam int MODE_BITS   = 2;
   localparam int PRIO_BITS   = 16;
   localparam int SLOT_BITS   = 11;
   localparam int TOTAL_BITS  = 11;
   localparam int STATUS_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_INSERT   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_EXTRACT  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INCREASE = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_BAD_SLOT = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/max_heap_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of priorities kept in a single-write, dual-read memory.
// ----------------------------------------------------------------------------
// A request beat on the req_ channel carries a mode (insert, extract maximum
// or increase priority at a one-based slot), a value and a slot index. Each
// request yields exactly one response beat on the rsp_ channel with the
// removed root, the new maximum, the entry count, an empty flag and a status.
// Requests that find the heap full, empty or the slot out of range change
// nothing and only report their status.
// The heap is walked one level at a time by a small sequencer around the
// memory: each level has a read state that issues the read and a compare
// state that compares the registered read data and fills the current hole.
// An increase first reads its slot and adds the value, and an extract first
// loads the last entry as the one to sift down from the root; a rejected
// request or the unused mode goes straight to the finish state. req_ready
// is high only while the sequencer is idle, so the next request is taken
// at the soonest on the edge after the response edge.
// The response sits in an output register; a new request is taken while it
// waits, and if the receiver still stalls when that request finishes, the
// sequencer holds in its final state until the register frees.
// Synchronous reset empties the heap and drops any pending response; the
// memory itself is not cleared since only slots 1 to the count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_unit #(
   parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = mhpq_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [mhpq_pkg::MODE_BITS-1:0]  req_mode,
   input  wire logic [mhpq_pkg::PRIO_BITS-1:0]  req_priority_value,
   input  wire logic [mhpq_pkg::SLOT_BITS-1:0]  req_slot_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [mhpq_pkg::PRIO_BITS-1:0]       rsp_removed_value,
   output logic [mhpq_pkg::PRIO_BITS-1:0]       rsp_top_value,
   output logic [mhpq_pkg::TOTAL_BITS-1:0]      rsp_entry_total,
   output logic                                 rsp_is_empty,
   output logic [mhpq_pkg::STATUS_BITS-1:0]     rsp_status
);
   import mhpq_pkg::*;

   // Count holds 0..CAPACITY; slots are one-based, memory addresses zero-based.
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CMP_BITS  = (CNT_BITS > SLOT_BITS) ? CNT_BITS : SLOT_BITS;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_UP_RD   = 10'b00_0000_0010,
      S_UP_CMP  = 10'b00_0000_0100,
      S_INC_RD  = 10'b00_0000_1000,
      S_INC_ADD = 10'b00_0001_0000,
      S_EXT_RD  = 10'b00_0010_0000,
      S_EXT_LD  = 10'b00_0100_0000,
      S_DN_RD   = 10'b00_1000_0000,
      S_DN_CMP  = 10'b01_0000_0000,
      S_FINISH  = 10'b10_0000_0000
   } state_type;

   function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [CNT_BITS:0] s);
      logic [CNT_BITS:0] m;
      m = s - 1'b1;
      return m[ADDR_BITS-1:0];
   endfunction

   logic [VALUE_BITS-1:0] heap_mem [CAPACITY];

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     k_ff, k_in;
   logic [VALUE_BITS-1:0]   cur_ff, cur_in;
   logic [VALUE_BITS-1:0]   root_ff, root_in;
   logic [VALUE_BITS-1:0]   removed_ff, removed_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [VALUE_BITS-1:0]   rd_a_ff, rd_b_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PRIO_BITS-1:0]    rsp_removed_ff, rsp_removed_in;
   logic [PRIO_BITS-1:0]    rsp_top_ff, rsp_top_in;
   logic [TOTAL_BITS-1:0]   rsp_total_ff, rsp_total_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [VALUE_BITS-1:0]   wr_data;
   logic [ADDR_BITS-1:0]    rd_addr_a, rd_addr_b;

   logic [CNT_BITS:0]       k_ext, left_slot, right_slot, count_ext;
   logic [VALUE_BITS:0]     inc_sum;
   logic                    pick_right;
   logic [VALUE_BITS-1:0]   pick_val;
   logic                    req_beat;
   logic                    rsp_free;

   assign k_ext      = {1'b0, k_ff};
   assign left_slot  = {k_ff, 1'b0};
   assign right_slot = {k_ff, 1'b1};
   assign count_ext  = {1'b0, count_ff};
   assign inc_sum    = {1'b0, rd_a_ff} + {1'b0, cur_ff};
   assign pick_right = (right_slot <= count_ext) && (rd_b_ff > rd_a_ff);
   assign pick_val   = pick_right ? rd_b_ff : rd_a_ff;
   assign req_beat   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);

   // Read addresses follow the state, k and the count; the read data is registered.
   always_comb begin
      rd_addr_a = slot_addr(k_ext >> 1);
      rd_addr_b = slot_addr(right_slot);
      case (state_ff)
         S_INC_RD: rd_addr_a = slot_addr(k_ext);
         S_EXT_RD: rd_addr_a = slot_addr(count_ext);
         S_DN_RD:  rd_addr_a = slot_addr(left_slot);
         default:  rd_addr_a = slot_addr(k_ext >> 1);
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      cur_in         = cur_ff;
      root_in        = root_ff;
      removed_in     = removed_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = slot_addr(k_ext);
      wr_data        = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               removed_in = '0;
               status_in  = STAT_OK;
               cur_in     = VALUE_BITS'(req_priority_value);
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_BITS'(CAPACITY)) begin
                        status_in = STAT_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        count_in = count_ff + 1'b1;
                        k_in     = count_ff + 1'b1;
                        state_in = S_UP_RD;
                     end
                  end
                  MODE_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        removed_in = root_ff;
                        state_in   = S_EXT_RD;
                     end
                  end
                  MODE_INCREASE: begin
                     if ((req_slot_index == '0) ||
                         (CMP_BITS'(req_slot_index) > CMP_BITS'(count_ff))) begin
                        status_in = STAT_BAD_SLOT;
                        state_in  = S_FINISH;
                     end else begin
                        k_in     = CNT_BITS'(req_slot_index);
                        state_in = S_INC_RD;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_INC_RD: begin
            state_in = S_INC_ADD;
         end

         S_INC_ADD: begin
            // Saturate at the top of the value range.
            cur_in   = inc_sum[VALUE_BITS] ? '1 : inc_sum[VALUE_BITS-1:0];
            state_in = S_UP_RD;
         end

         S_UP_RD: begin
            if (k_ff == CNT_BITS'(1)) begin
               wr_en    = 1'b1;
               root_in  = cur_ff;
               state_in = S_FINISH;
            end else begin
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            // The moving entry is held in cur_ff; a smaller parent drops into the hole.
            wr_en = 1'b1;
            if (rd_a_ff < cur_ff) begin
               wr_data  = rd_a_ff;
               k_in     = k_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_EXT_RD: begin
            count_in = count_ff - 1'b1;
            state_in = S_EXT_LD;
         end

         S_EXT_LD: begin
            cur_in   = rd_a_ff;
            k_in     = CNT_BITS'(1);
            state_in = S_DN_RD;
         end

         S_DN_RD: begin
            if (left_slot > count_ext) begin
               wr_en    = 1'b1;
               if (k_ff == CNT_BITS'(1)) begin
                  root_in = cur_ff;
               end
               state_in = S_FINISH;
            end else begin
               state_in = S_DN_CMP;
            end
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_val > cur_ff) begin
               wr_data = pick_val;
               if (k_ff == CNT_BITS'(1)) begin
                  root_in = pick_val;
               end
               k_in     = pick_right ? right_slot[CNT_BITS-1:0] : left_slot[CNT_BITS-1:0];
               state_in = S_DN_RD;
            end else begin
               if (k_ff == CNT_BITS'(1)) begin
                  root_in = cur_ff;
               end
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = PRIO_BITS'(removed_ff);
               rsp_top_in     = (count_ff == '0) ? '0 : PRIO_BITS'(root_ff);
               rsp_total_in   = TOTAL_BITS'(count_ff);
               rsp_empty_in   = (count_ff == '0);
               rsp_status_in  = status_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      cur_ff         <= cur_in;
      root_ff        <= root_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_entry_total   = rsp_total_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mhpq_checker.sv @@
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the heap queue, bound into every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mhpq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mhpq_pkg::PRIO_BITS-1:0]  rsp_removed_value,
   input wire logic [mhpq_pkg::PRIO_BITS-1:0]  rsp_top_value,
   input wire logic [mhpq_pkg::TOTAL_BITS-1:0] rsp_entry_total,
   input wire logic                            rsp_is_empty,
   input wire logic [mhpq_pkg::STATUS_BITS-1:0] rsp_status
);
   import mhpq_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `ASSERT_IMPL(a_empty_flag, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_total == '0), "empty flag disagrees with count")
   `ASSERT_IMPL(a_removed_ok, clock, reset, rsp_valid && (rsp_removed_value != '0), rsp_status == STAT_OK, "value removed by a failed request")
   `ASSERT_IMPL(a_top_order, clock, reset, rsp_valid && (rsp_removed_value != '0), rsp_top_value <= rsp_removed_value, "new maximum above removed root")
   `ASSERT_IMPL(a_empty_status, clock, reset, rsp_valid && (rsp_status == STAT_EMPTY), rsp_is_empty && (rsp_top_value == '0), "empty status on a non-empty heap")

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_removed_value (rsp_removed_value),
   .rsp_top_value     (rsp_top_value),
   .rsp_entry_total   (rsp_entry_total),
   .rsp_is_empty      (rsp_is_empty),
   .rsp_status        (rsp_status)
);

`default_nettype wire

@@ sim/max_heap_priority_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit_tb
// Self-checking bench for the heap queue: directed corner requests, a long
// random mix, back-pressure, a quiet restart, a deep fill and drain of the
// heap. A behavioral mirror of every request beat predicts each response.
// ----------------------------------------------------------------------------

module max_heap_priority_queue_unit_tb;

   import mhpq_pkg::*;

   localparam int HEAP_DEPTH  = CAPACITY_DEF;
   localparam int VALUE_WIDTH = VALUE_BITS_DEF;

   // Depth reached by the random fill, before two more inserts and the drain.
   localparam int FILL_DEPTH = 100;

   // Largest value the heap can hold; also masks the incoming value.
   localparam logic [PRIO_BITS-1:0] VALUE_TOP =
      PRIO_BITS'((64'd1 << VALUE_WIDTH) - 64'd1);

   // The fourth mode encoding is unused by the block and must be a no-op.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam logic [SLOT_BITS-1:0] SLOT_ALL_ONES = '1;

   // Generous watchdog limit for the whole run.
   localparam int CYCLE_LIMIT = 1000000;

   // One response beat, field for field.
   typedef struct packed {
      logic [PRIO_BITS-1:0]   removed_value;
      logic [PRIO_BITS-1:0]   top_value;
      logic [TOTAL_BITS-1:0]  entry_total;
      logic                   is_empty;
      logic [STATUS_BITS-1:0] status;
   } heap_result_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   logic [MODE_BITS-1:0]   req_mode           = '0;
   logic [PRIO_BITS-1:0]   req_priority_value = '0;
   logic [SLOT_BITS-1:0]   req_slot_index     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   logic [PRIO_BITS-1:0]   rsp_removed_value;
   logic [PRIO_BITS-1:0]   rsp_top_value;
   logic [TOTAL_BITS-1:0]  rsp_entry_total;
   logic                   rsp_is_empty;
   logic [STATUS_BITS-1:0] rsp_status;

   // Mirror of the heap contents and its entry count.
   logic [PRIO_BITS-1:0] heap_mirror [1:HEAP_DEPTH];
   int unsigned          mirror_count = 0;

   // Responses still owed by the block, oldest first.
   heap_result_type owed_responses [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned response_count = 0;

   // Idle controls for the two sides, and the long receiver hold request.
   bit          req_gaps_on   = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;
   int unsigned stall_left    = 0;

   max_heap_priority_queue_unit #(
      .CAPACITY   (HEAP_DEPTH),
      .VALUE_BITS (VALUE_WIDTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_priority_value (req_priority_value),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_top_value      (rsp_top_value),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_status         (rsp_status)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hang anywhere in the run ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("max_heap_priority_queue_unit verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Heap mirror
   // ------------------------------------------------------------------------

   // Moves the entry at slot k up while it is strictly larger than its parent.
   function automatic void mirror_sift_up(int unsigned k);
      logic [PRIO_BITS-1:0] held;
      while (k > 1 && heap_mirror[k / 2] < heap_mirror[k]) begin
         held               = heap_mirror[k];
         heap_mirror[k]     = heap_mirror[k / 2];
         heap_mirror[k / 2] = held;
         k                  = k / 2;
      end
   endfunction

   // Applies one request to the mirror and returns the response it must give.
   function automatic heap_result_type apply_heap_request(
      logic [MODE_BITS-1:0] mode,
      logic [PRIO_BITS-1:0] amount,
      logic [SLOT_BITS-1:0] slot
   );
      heap_result_type      res;
      logic [PRIO_BITS-1:0] value;
      logic [PRIO_BITS-1:0] held;
      int unsigned          k;
      int unsigned          pick;
      int unsigned          sum;
      res   = '0;
      value = amount & VALUE_TOP;
      case (mode)
         MODE_INSERT: begin
            if (mirror_count >= HEAP_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               mirror_count              = mirror_count + 1;
               heap_mirror[mirror_count] = value;
               mirror_sift_up(mirror_count);
            end
         end
         MODE_EXTRACT: begin
            if (mirror_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.removed_value = heap_mirror[1];
               heap_mirror[1]    = heap_mirror[mirror_count];
               mirror_count      = mirror_count - 1;
               // Sift down along the larger child; ties keep the left child
               // and never swap with an equal entry.
               k = 1;
               while (2 * k <= mirror_count) begin
                  pick = 2 * k;
                  if (pick + 1 <= mirror_count && heap_mirror[pick + 1] > heap_mirror[pick])
                     pick = pick + 1;
                  if (heap_mirror[pick] > heap_mirror[k]) begin
                     held              = heap_mirror[k];
                     heap_mirror[k]    = heap_mirror[pick];
                     heap_mirror[pick] = held;
                     k                 = pick;
                  end else begin
                     break;
                  end
               end
            end
         end
         MODE_INCREASE: begin
            if (slot == 0 || slot > mirror_count) begin
               res.status = STAT_BAD_SLOT;
            end else begin
               sum = heap_mirror[slot] + value;
               if (sum > VALUE_TOP)
                  sum = VALUE_TOP;
               heap_mirror[slot] = PRIO_BITS'(sum);
               mirror_sift_up(slot);
            end
         end
         default: begin
            // Unused mode: nothing changes and status stays OK.
         end
      endcase
      res.top_value   = (mirror_count > 0) ? heap_mirror[1] : '0;
      res.entry_total = TOTAL_BITS'(mirror_count);
      res.is_empty    = (mirror_count == 0);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(string field_name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response beat %0d %s got %0h want %0h",
                                   response_count, field_name, got, want));
   endtask

   // Each accepted response beat is compared with the oldest one owed.
   always @(posedge clock) begin : check_responses
      heap_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("response beat %0d arrived with none owed",
                                      response_count));
         end else begin
            want = owed_responses.pop_front();
            check_field("removed_value", rsp_removed_value, want.removed_value);
            check_field("top_value", rsp_top_value, want.top_value);
            check_field("entry_total", rsp_entry_total, want.entry_total);
            check_field("is_empty", rsp_is_empty, want.is_empty);
            check_field("status", rsp_status, want.status);
         end
         response_count++;
      end
   end

   // The receiver. A long hold takes priority; otherwise, when enabled, it
   // stalls in random bursts of random length.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one request beat and waits for it to be taken. Valid is left high
   // so that back-to-back beats never lower and raise it in one step; gaps
   // lower it first.
   task automatic send_heap_request(
      logic [MODE_BITS-1:0] mode,
      logic [PRIO_BITS-1:0] value,
      logic [SLOT_BITS-1:0] slot
   );
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_priority_value <= value;
      req_slot_index     <= slot;
      do @(posedge clock); while (req_ready !== 1'b1);
      owed_responses.push_back(apply_heap_request(mode, value, slot));
   endtask

   // Drops valid and waits until every owed response has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_responses.size() != 0);
   endtask

   // Random payload, biased toward ties near zero and toward the top value.
   function automatic logic [PRIO_BITS-1:0] random_priority();
      case ($urandom_range(0, 9))
         0, 1, 2: return PRIO_BITS'($urandom_range(0, 7));
         3:       return VALUE_TOP - PRIO_BITS'($urandom_range(0, 15));
         4:       return ($urandom_range(0, 1) != 0) ? VALUE_TOP : '0;
         default: return PRIO_BITS'($urandom());
      endcase
   endfunction

   // One random request shaped to keep the heap busy at moderate depth:
   // mostly well-formed operations, with bad slots and the unused mode mixed in.
   task automatic send_random_request();
      int unsigned          pick;
      int unsigned          insert_share;
      logic [PRIO_BITS-1:0] amount;
      logic [SLOT_BITS-1:0] slot;
      pick         = $urandom_range(0, 99);
      insert_share = (mirror_count > 48) ? 30 : 45;
      slot         = SLOT_BITS'($urandom());
      if (pick < 5) begin
         send_heap_request(MODE_UNUSED, PRIO_BITS'($urandom()), slot);
      end else if (pick < 5 + insert_share) begin
         send_heap_request(MODE_INSERT, random_priority(), slot);
      end else if (pick < 75) begin
         send_heap_request(MODE_EXTRACT, PRIO_BITS'($urandom()), slot);
      end else begin
         amount = ($urandom_range(0, 2) == 0) ? random_priority()
                                              : PRIO_BITS'($urandom_range(0, 300));
         if (mirror_count > 0 && $urandom_range(0, 99) < 85)
            slot = SLOT_BITS'($urandom_range(1, mirror_count));
         else if ($urandom_range(0, 3) == 0)
            slot = '0;
         else
            slot = SLOT_BITS'($urandom_range(mirror_count + 1, 2047));
         send_heap_request(MODE_INCREASE, amount, slot);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corner requests from an empty heap: every mode, the value extremes,
   // every kind of bad slot, saturation, equal priorities and extract of the
   // last entries down to empty.
   task automatic test_directed_corners();
      send_heap_request(MODE_EXTRACT, '0, '0);              // empty heap
      send_heap_request(MODE_INCREASE, 16'd5, 11'd1);       // slot past count
      send_heap_request(MODE_INCREASE, VALUE_TOP, '0);      // slot zero
      send_heap_request(MODE_UNUSED, '1, SLOT_ALL_ONES);
      send_heap_request(MODE_INSERT, '0, '0);
      send_heap_request(MODE_INSERT, VALUE_TOP, SLOT_ALL_ONES);
      send_heap_request(MODE_INSERT, 16'h1234, '0);
      send_heap_request(MODE_INSERT, 16'h1234, '0);         // equal priorities
      send_heap_request(MODE_INSERT, 16'h8000, '0);
      send_heap_request(MODE_INSERT, 16'h7FFF, '0);
      send_heap_request(MODE_INCREASE, 16'd1, '0);          // slot zero, not empty
      send_heap_request(MODE_INCREASE, 16'd1, 11'd7);       // one past the count
      send_heap_request(MODE_INCREASE, 16'd1, SLOT_ALL_ONES);
      send_heap_request(MODE_INCREASE, VALUE_TOP, 11'd6);   // saturates
      send_heap_request(MODE_INCREASE, '0, 11'd6);          // zero amount
      send_heap_request(MODE_INCREASE, 16'd1, 11'd3);
      send_heap_request(MODE_UNUSED, '0, '0);
      send_heap_request(MODE_INSERT, 16'h5555, '0);
      send_heap_request(MODE_INSERT, 16'hAAAA, '0);
      repeat (9) send_heap_request(MODE_EXTRACT, '0, '0);   // down to empty and one more
   endtask

   // Long random mix in segments; idling on both sides changes per segment
   // so that there are stretches with and without gaps.
   task automatic test_random_mix();
      for (int seg = 0; seg < 4; seg++) begin
         req_gaps_on   = (seg == 0) ? 1'b1 : (seg == 1) ? 1'b0 : bit'($urandom_range(0, 1));
         rsp_stalls_on = (seg == 0) ? 1'b1 : (seg == 1) ? 1'b0 : bit'($urandom_range(0, 1));
         repeat (110) send_random_request();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver holds off while requests keep coming, so the output
   // register fills, the next result waits in the sequencer, and the request
   // side stalls.
   task automatic test_response_backpressure();
      req_gaps_on  = 1'b0;
      hold_request = 300;
      repeat (12) send_random_request();
      req_gaps_on = 1'b1;
   endtask

   // The sender goes quiet until everything is back, then restarts cold.
   task automatic test_quiet_restart();
      wait_until_drained();
      repeat (25) send_random_request();
   endtask

   // Fills the heap several levels deep, increases the last slot and tries the
   // one past it, drains it completely so as to check the whole heap order,
   // then extracts from empty and inserts and extracts once. No idling.
   task automatic test_fill_and_drain();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      while (mirror_count < FILL_DEPTH)
         send_heap_request(MODE_INSERT, random_priority(), SLOT_BITS'($urandom()));
      send_heap_request(MODE_INSERT, VALUE_TOP, '0);
      send_heap_request(MODE_INSERT, '0, SLOT_ALL_ONES);
      send_heap_request(MODE_INCREASE, PRIO_BITS'($urandom()), SLOT_BITS'(mirror_count));
      send_heap_request(MODE_INCREASE, 16'd1, SLOT_BITS'(mirror_count + 1));
      while (mirror_count > 0)
         send_heap_request(MODE_EXTRACT, PRIO_BITS'($urandom()), SLOT_BITS'($urandom()));
      send_heap_request(MODE_EXTRACT, '0, '0);              // empty again
      send_heap_request(MODE_INSERT, 16'h00FF, '0);
      send_heap_request(MODE_EXTRACT, '0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_mix();
      test_response_backpressure();
      test_quiet_restart();
      test_fill_and_drain();

      // Let any stray beat show up before the verdict.
      wait_until_drained();
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && owed_responses.size() == 0) begin
         $display("max_heap_priority_queue_unit verification clean");
      end else begin
         $display("max_heap_priority_queue_unit verification failed");
      end
      $finish;
   end

endmodule
